// File: sv/ngoop_pkg.sv
// Shared types and constants of the n-gram out-of-place distance block.
package ngoop_pkg;

   localparam int PROFILE_ENTRIES_DEF = 512;
   localparam int NGRAM_CHARS_DEF     = 5;

   localparam int KEY_PORT_W = 40;
   localparam int RANK_W     = 9;
   localparam int DOC_W      = 16;
   localparam int DIST_W     = 32;
   localparam int PENALTY_W  = 16;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;

   localparam logic [PENALTY_W-1:0] PENALTY_RESET = 16'd400;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_SCORE = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REQ,
      ST_LOOK,
      ST_ACC
   } state_type;

endpackage

// File: sv/ngoop_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ngoop_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ngram_out_of_place_distance.sv
// Top level: out-of-place distance of a document fingerprint against one stored profile.
//
// The profile sits in one hashed table RAM (valid, key, rank per slot) searched by linear
// probing; each probe passes ST_REQ (address), then ST_LOOK (compare of the registered read
// data). A load or score item makes 1..PROFILE_ENTRIES probes (a few at moderate fill), and
// a score item then passes ST_ACC for the saturating accumulate. A clear item sweeps the
// table one slot a cycle in ST_CLEAR; the same sweep runs after reset, with busy high while
// it runs. An unused mode code answers from ST_IDLE without a table access. Every item
// gives exactly one result, shown for one cycle under rsp_valid; the receiver cannot
// stall, and a new item can be taken in the cycle its predecessor's result is shown. The
// penalty register takes writes at any time and should be changed only idle.
module ngram_out_of_place_distance #(
   parameter int PROFILE_ENTRIES = ngoop_pkg::PROFILE_ENTRIES_DEF,
   parameter int NGRAM_CHARS     = ngoop_pkg::NGRAM_CHARS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ngoop_pkg::MODE_W-1:0]       req_mode,
   input  logic [ngoop_pkg::KEY_PORT_W-1:0]   req_ngram_key,
   input  logic [ngoop_pkg::RANK_W-1:0]       req_profile_rank,
   input  logic                               req_last,
   output logic                               rsp_valid,
   output logic [ngoop_pkg::DIST_W-1:0]       rsp_total_distance,
   output logic                               rsp_distance_ready,
   output logic                               rsp_key_found,
   output logic [ngoop_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ngoop_pkg::PENALTY_W-1:0]    csr_data
);
   import ngoop_pkg::*;

   localparam int ADDR_W  = $clog2(PROFILE_ENTRIES);
   localparam int CNT_W   = $clog2(PROFILE_ENTRIES + 1);
   localparam int KEY_W   = (8 * NGRAM_CHARS < KEY_PORT_W) ? 8 * NGRAM_CHARS : KEY_PORT_W;
   localparam int ENTRY_W = 1 + KEY_W + RANK_W;

   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(PROFILE_ENTRIES - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(PROFILE_ENTRIES);
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [DOC_W-1:0]  DOC_MAX  = '1;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0]     probe_ff, probe_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DOC_W-1:0]      doc_ff, doc_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [DOC_W-1:0]      add_ff, add_in;
   logic                  found_ff, found_in;
   logic [PENALTY_W-1:0]  penalty_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                  rsp_ready_ff, rsp_ready_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [ENTRY_W-1:0]    rd_data;

   logic                  rd_valid;
   logic [KEY_W-1:0]      rd_key;
   logic [RANK_W-1:0]     rd_rank;
   logic [ADDR_W-1:0]     next_idx;
   logic [KEY_W-1:0]      req_key;
   logic [DIST_W:0]       sum;
   logic [DIST_W-1:0]     new_dist;

   function automatic logic [ADDR_W-1:0] hash_key(input logic [KEY_W-1:0] key);
      logic [ADDR_W-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % ADDR_W] = h[i % ADDR_W] ^ key[i];
      end
      if ({1'b0, h} >= (ADDR_W + 1)'(PROFILE_ENTRIES)) begin
         h = h - ADDR_W'(PROFILE_ENTRIES);
      end
      return h;
   endfunction

   ngoop_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PROFILE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign rd_valid = rd_data[ENTRY_W-1];
   assign rd_key   = rd_data[RANK_W +: KEY_W];
   assign rd_rank  = rd_data[RANK_W-1:0];
   assign next_idx = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign req_key  = req_ngram_key[KEY_W-1:0];
   assign sum      = {1'b0, dist_ff} + (DIST_W + 1)'(add_ff);
   assign new_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         doc_ff       <= '0;
         dist_ff      <= '0;
         penalty_ff   <= PENALTY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         doc_ff       <= doc_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            penalty_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      rank_ff       <= rank_in;
      last_ff       <= last_in;
      add_ff        <= add_in;
      found_ff      <= found_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_ready_ff  <= rsp_ready_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      probe_in      = probe_ff;
      clr_rsp_in    = clr_rsp_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      rank_in       = rank_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      doc_in        = doc_ff;
      dist_in       = dist_ff;
      add_in        = add_ff;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      rsp_total_in  = '0;
      rsp_ready_in  = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = next_idx;
            if (idx_ff == LAST_IDX) begin
               state_in     = ST_IDLE;
               rsp_valid_in = clr_rsp_ff;
               clr_rsp_in   = 1'b0;
            end
         end
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               key_in   = req_key;
               rank_in  = req_profile_rank;
               last_in  = req_last;
               probe_in = '0;
               idx_in   = hash_key(req_key);
               case (req_mode)
                  MODE_CLEAR: begin
                     idx_in     = '0;
                     count_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  MODE_LOAD, MODE_SCORE: begin
                     state_in = ST_REQ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_REQ: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (rd_valid && rd_key == key_ff) begin
               if (mode_ff == MODE_LOAD) begin
                  wr_en        = 1'b1;
                  wr_data      = {1'b1, key_ff, rank_ff};
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  add_in   = (DOC_W'(rd_rank) >= doc_ff) ? DOC_W'(rd_rank) - doc_ff
                                                         : doc_ff - DOC_W'(rd_rank);
                  found_in = 1'b1;
                  state_in = ST_ACC;
               end
            end else if (!rd_valid || probe_ff == LAST_IDX) begin
               if (mode_ff == MODE_LOAD) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (!rd_valid && count_ff < FULL_CNT) begin
                     wr_en    = 1'b1;
                     wr_data  = {1'b1, key_ff, rank_ff};
                     count_in = count_ff + 1'b1;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end else begin
                  add_in   = DOC_W'(penalty_ff);
                  found_in = 1'b0;
                  state_in = ST_ACC;
               end
            end else begin
               idx_in   = next_idx;
               probe_in = probe_ff + 1'b1;
               state_in = ST_REQ;
            end
         end
         ST_ACC: begin
            rsp_valid_in  = 1'b1;
            rsp_found_in  = found_ff;
            rsp_status_in = (new_dist == DIST_MAX) ? STATUS_SAT : STATUS_OK;
            dist_in       = new_dist;
            doc_in        = (doc_ff == DOC_MAX) ? doc_ff : doc_ff + 1'b1;
            if (last_ff) begin
               rsp_total_in = new_dist;
               rsp_ready_in = 1'b1;
               dist_in      = '0;
               doc_in       = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_distance = rsp_total_ff;
   assign rsp_distance_ready = rsp_ready_ff;
   assign rsp_key_found      = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond table size");

   a_found_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_found |-> rsp_status != STATUS_FULL)
      else $error("found key reported with full status");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_LOAD || req_mode == MODE_SCORE) |=> busy && !rsp_valid)
      else $error("search item not held busy");

   a_ready_from_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance_ready |-> $past(state_ff) == ST_ACC)
      else $error("distance ready outside score accumulate");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the n-gram out-of-place distance block.
module testbench;
   import ngoop_pkg::*;

   localparam int ENTRIES = PROFILE_ENTRIES_DEF;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam int DOC_MAX = 65535;
   localparam longint CYCLE_LIMIT = 8_000_000;
   localparam int DRAIN_CYCLES = 1100;
   localparam int PRINT_LIMIT = 60;
   localparam logic [KEY_PORT_W-1:0] KEY_ONES = '1;
   localparam logic [KEY_PORT_W-1:0] KEY_ABC = 40'h00_0063_6261;
   localparam logic [KEY_PORT_W-1:0] KEY_HI_LO = 40'h80_0000_0001;
   localparam logic [KEY_PORT_W-1:0] KEY_FIVES = 40'h55_5555_5555;
   localparam logic [KEY_PORT_W-1:0] KEY_TENS = 40'hAA_AAAA_AAAA;

   typedef struct {
      logic [MODE_W-1:0]     mode;
      logic [KEY_PORT_W-1:0] key;
      logic [RANK_W-1:0]     rank;
      logic                  last;
   } ngram_item_type;

   typedef struct {
      logic [DIST_W-1:0] total;
      logic              ready;
      logic              found;
      status_type        status;
   } distance_result_type;

   typedef struct {
      ngram_item_type      item;
      bit                  typed;
      distance_result_type result;
   } directed_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [MODE_W-1:0] req_mode;
   logic [KEY_PORT_W-1:0] req_ngram_key;
   logic [RANK_W-1:0] req_profile_rank;
   logic req_last;
   logic rsp_valid;
   logic [DIST_W-1:0] rsp_total_distance;
   logic rsp_distance_ready;
   logic rsp_key_found;
   logic [STATUS_W-1:0] rsp_status;
   logic csr_valid;
   logic csr_ready;
   logic [PENALTY_W-1:0] csr_data;

   // profile predictor state
   logic [KEY_PORT_W-1:0] prof_key [ENTRIES];
   logic [RANK_W-1:0] prof_rank [ENTRIES];
   int prof_count;
   int doc_rank;
   logic [DIST_W-1:0] run_dist;
   logic [PENALTY_W-1:0] penalty;

   distance_result_type pending_results [$];
   distance_result_type head_result;
   int mismatch_count = 0;
   int items_sent = 0;
   int idle_pct = 0;
   longint cycle_count = 0;

   ngram_out_of_place_distance dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_ngram_key      (req_ngram_key),
      .req_profile_rank   (req_profile_rank),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_total_distance (rsp_total_distance),
      .rsp_distance_ready (rsp_distance_ready),
      .rsp_key_found      (rsp_key_found),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 64'(rsp_total_distance), '0);
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_total_distance !== head_result.total)
               report_mismatch("total_distance", 64'(rsp_total_distance),
                               64'(head_result.total));
            if (rsp_distance_ready !== head_result.ready)
               report_mismatch("distance_ready", 64'(rsp_distance_ready),
                               64'(head_result.ready));
            if (rsp_key_found !== head_result.found)
               report_mismatch("key_found", 64'(rsp_key_found), 64'(head_result.found));
            if (rsp_status !== head_result.status)
               report_mismatch("status", 64'(rsp_status), 64'(head_result.status));
         end
      end
   end

   function automatic int find_profile_slot(input logic [KEY_PORT_W-1:0] key);
      for (int i = 0; i < prof_count; i++)
         if (prof_key[i] == key) return i;
      return -1;
   endfunction

   function automatic distance_result_type predict_distance(input ngram_item_type it);
      distance_result_type r;
      int slot;
      int pr;
      longint add;
      longint sum;
      r.total = '0;
      r.ready = 1'b0;
      r.found = 1'b0;
      r.status = STATUS_OK;
      slot = find_profile_slot(it.key);
      case (it.mode)
         MODE_CLEAR: prof_count = 0;
         MODE_LOAD: begin
            if (slot >= 0) begin
               prof_rank[slot] = it.rank;
            end else if (prof_count < ENTRIES) begin
               prof_key[prof_count] = it.key;
               prof_rank[prof_count] = it.rank;
               prof_count++;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         MODE_SCORE: begin
            if (slot >= 0) begin
               pr = int'(prof_rank[slot]);
               add = (pr >= doc_rank) ? pr - doc_rank : doc_rank - pr;
               r.found = 1'b1;
            end else begin
               add = longint'(penalty);
            end
            sum = longint'(run_dist) + add;
            run_dist = (sum > 64'h0000_0000_FFFF_FFFF) ? DIST_MAX : sum[DIST_W-1:0];
            if (run_dist == DIST_MAX) r.status = STATUS_SAT;
            if (doc_rank < DOC_MAX) doc_rank++;
            if (it.last) begin
               r.total = run_dist;
               r.ready = 1'b1;
               run_dist = '0;
               doc_rank = 0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic issue_item(input ngram_item_type it, input bit typed,
                             input distance_result_type want);
      distance_result_type predicted;
      int gap;
      req_mode <= it.mode;
      req_ngram_key <= it.key;
      req_profile_rank <= it.rank;
      req_last <= it.last;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_distance(it);
      pending_results.push_back(typed ? want : predicted);
      if (it.mode != MODE_UNUSED) items_sent++;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 200) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue_ngram(input logic [MODE_W-1:0] mode, input logic [KEY_PORT_W-1:0] key,
                              input logic [RANK_W-1:0] rank, input logic last);
      ngram_item_type it;
      distance_result_type unused_result;
      it.mode = mode;
      it.key = key;
      it.rank = rank;
      it.last = last;
      unused_result.total = '0;
      unused_result.ready = 1'b0;
      unused_result.found = 1'b0;
      unused_result.status = STATUS_OK;
      issue_item(it, 1'b0, unused_result);
   endtask

   task automatic settle_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_penalty(input logic [PENALTY_W-1:0] value);
      settle_results();
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      penalty = value;
   endtask

   function automatic directed_row_type known_row(input logic [MODE_W-1:0] mode,
         input logic [KEY_PORT_W-1:0] key, input logic [RANK_W-1:0] rank, input logic last,
         input logic [DIST_W-1:0] total, input logic ready, input logic found,
         input status_type status);
      directed_row_type row;
      row.item.mode = mode;
      row.item.key = key;
      row.item.rank = rank;
      row.item.last = last;
      row.typed = 1'b1;
      row.result.total = total;
      row.result.ready = ready;
      row.result.found = found;
      row.result.status = status;
      return row;
   endfunction

   function automatic directed_row_type plain_row(input logic [MODE_W-1:0] mode,
         input logic [KEY_PORT_W-1:0] key, input logic [RANK_W-1:0] rank, input logic last);
      directed_row_type row;
      row = known_row(mode, key, rank, last, '0, 1'b0, 1'b0, STATUS_OK);
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic logic [KEY_PORT_W-1:0] random_ngram();
      logic [KEY_PORT_W-1:0] k;
      int chars;
      k = {8'($urandom()), 32'($urandom())};
      if ($urandom_range(1) == 1) begin
         chars = $urandom_range(1, NGRAM_CHARS_DEF);
         k = k & ((40'd1 << (8 * chars)) - 40'd1);
      end
      return k;
   endfunction

   function automatic logic [KEY_PORT_W-1:0] pick_ngram();
      if (prof_count > 0 && $urandom_range(99) < 65)
         return prof_key[$urandom_range(prof_count - 1)];
      return random_ngram();
   endfunction

   task automatic issue_noise();
      case ($urandom_range(3))
         0: issue_ngram(MODE_UNUSED, random_ngram(), 9'($urandom()), 1'($urandom()));
         1: issue_ngram(MODE_LOAD, random_ngram(), 9'($urandom()), 1'($urandom()));
         2: issue_ngram(MODE_CLEAR, random_ngram(), 9'($urandom()), 1'($urandom()));
         default: issue_ngram(MODE_LOAD, pick_ngram(), 9'($urandom()), 1'($urandom()));
      endcase
   endtask

   task automatic run_random_documents(input int quota, input int pct);
      int target;
      int n_load;
      int n_docs;
      int len;
      logic [PENALTY_W-1:0] value;
      target = items_sent + quota;
      idle_pct = pct;
      while (items_sent < target) begin
         case ($urandom_range(5))
            0: value = '0;
            1: value = '1;
            2: value = 16'($urandom_range(1, 16));
            default: value = 16'($urandom());
         endcase
         write_penalty(value);
         if ($urandom_range(3) != 0 || prof_count > 200)
            issue_ngram(MODE_CLEAR, random_ngram(), 9'($urandom()), 1'($urandom()));
         n_load = ($urandom_range(11) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 20);
         repeat (n_load)
            issue_ngram(MODE_LOAD, random_ngram(), 9'($urandom()), 1'($urandom()));
         n_docs = $urandom_range(1, 4);
         repeat (n_docs) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 25);
            for (int j = 0; j < len; j++) begin
               if ($urandom_range(19) == 0) issue_noise();
               issue_ngram(MODE_SCORE, pick_ngram(), 9'($urandom()), j == len - 1);
            end
            if ($urandom_range(15) == 0) settle_results();
         end
      end
   endtask

   initial begin
      directed_row_type rows [$];
      logic [KEY_PORT_W-1:0] fill_keys [ENTRIES];
      logic [KEY_PORT_W-1:0] stranger;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_CLEAR;
      req_ngram_key = '0;
      req_profile_rank = '0;
      req_last = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      prof_count = 0;
      doc_rank = 0;
      run_dist = '0;
      penalty = PENALTY_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(known_row(MODE_SCORE, '0, '0, 1'b1, 32'd400, 1'b1, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_UNUSED, KEY_ONES, 9'h1FF, 1'b1, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_LOAD, KEY_ONES, 9'h1FF, 1'b1, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_LOAD, '0, '0, 1'b0, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_LOAD, KEY_ABC, 9'd7, 1'b0, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_LOAD, KEY_ABC, 9'd300, 1'b0, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_SCORE, '0, '0, 1'b0, '0, 1'b0, 1'b1, STATUS_OK));
      rows.push_back(plain_row(MODE_SCORE, KEY_ABC, '0, 1'b0));
      rows.push_back(plain_row(MODE_SCORE, 40'h1, '0, 1'b0));
      rows.push_back(plain_row(MODE_SCORE, KEY_ONES, '0, 1'b1));
      rows.push_back(known_row(MODE_CLEAR, KEY_ONES, 9'h1FF, 1'b1, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(plain_row(MODE_SCORE, KEY_ABC, '0, 1'b0));
      rows.push_back(known_row(MODE_CLEAR, '0, '0, 1'b0, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_LOAD, KEY_HI_LO, 9'd256, 1'b0, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(plain_row(MODE_SCORE, KEY_HI_LO, '0, 1'b1));
      rows.push_back(known_row(MODE_LOAD, KEY_FIVES, 9'h155, 1'b0, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(known_row(MODE_LOAD, KEY_TENS, 9'h0AA, 1'b1, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(plain_row(MODE_SCORE, KEY_TENS, 9'h1FF, 1'b0));
      rows.push_back(plain_row(MODE_SCORE, KEY_FIVES, '0, 1'b0));
      rows.push_back(plain_row(MODE_SCORE, 40'h61, '0, 1'b1));
      rows.push_back(known_row(MODE_UNUSED, '0, '0, 1'b0, '0, 1'b0, 1'b0, STATUS_OK));
      rows.push_back(plain_row(MODE_SCORE, KEY_FIVES, '0, 1'b1));

      idle_pct = 13;
      foreach (rows[i]) issue_item(rows[i].item, rows[i].typed, rows[i].result);

      run_random_documents(310, 13);
      run_random_documents(310, 86);

      // fill the table to capacity, then a new key is dropped
      idle_pct = 0;
      write_penalty('0);
      issue_ngram(MODE_CLEAR, '0, '0, 1'b0);
      for (int i = 0; i < ENTRIES; i++) begin
         fill_keys[i] = {31'($urandom()), 9'(i)};
         issue_ngram(MODE_LOAD, fill_keys[i], 9'($urandom()), 1'($urandom()));
      end
      stranger = fill_keys[0] ^ {1'b1, 39'd0};
      issue_ngram(MODE_LOAD, stranger, 9'd5, 1'b0);
      issue_ngram(MODE_LOAD, fill_keys[ENTRIES-1], 9'd1, 1'b0);
      issue_ngram(MODE_SCORE, fill_keys[ENTRIES-1], '0, 1'b0);
      issue_ngram(MODE_SCORE, stranger, '0, 1'b0);
      issue_ngram(MODE_SCORE, fill_keys[100], '0, 1'b1);
      issue_ngram(MODE_CLEAR, '0, '0, 1'b0);

      run_random_documents(310, 0);

      settle_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("items without result", 64'(pending_results.size()), '0);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
